// ===== rtl/cpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types and constants for the closest-points-between-rays core.
// ----------------------------------------------------------------------------
package cpr_pkg;

   localparam int unsigned DIV_STAGES  = 32;
   localparam int unsigned ROOT_STAGES = 32;

   localparam logic [31:0] LIMIT_RESET = 32'd43;
   localparam logic        IDX_LIMIT   = 1'b0;

   typedef struct packed {
      logic [2:0][31:0] d1;
      logic [2:0][31:0] d2;
      logic [2:0][32:0] w;
   } item_type;

   typedef struct packed {
      logic        valid;
      logic        full;
   } queue_stat_type;

   typedef struct packed {
      logic        valid;
      logic        parallel;
      logic [31:0] sc;
      logic [31:0] tc;
      item_type    item;
   } geom_type;

   typedef struct packed {
      logic        valid;
      logic        parallel;
      logic [31:0] param_one;
      logic [31:0] param_two;
      logic [31:0] separation;
   } result_type;

endpackage

// ===== rtl/closest_points_between_rays_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_points_between_rays_core
// Closest-point parameters and separation of two 3D lines in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Present both lines on the req_ ports and raise start; the item is taken
//   at a clock edge where start is high and busy is low. One item per cycle
//   is accepted without a gap.
//   Each item yields one result on the rsp_ ports, marked by rsp_strobe for
//   a single cycle, in acceptance order. rsp_strobe rises after the intake
//   and queue registers, the dot products, split multipliers and the two
//   32-step pipelined dividers, then the closest-point difference, its
//   square and the 32-step pipelined root.
//   The receiver cannot stall; the pipeline never holds results back.
//   busy rises only if the two-entry intake queue fills, which a steady
//   item per cycle does not cause.
//   parallel_limit sits at address 0 of the APB port and resets to 43. The
//   user writes it only while no item is in flight; the core does not check.
//   Synchronous reset empties the pipeline and queue and restores the limit.
// ----------------------------------------------------------------------------
module closest_points_between_rays_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_origin_one_x,
   input  logic [31:0] req_origin_one_y,
   input  logic [31:0] req_origin_one_z,
   input  logic [31:0] req_direction_one_x,
   input  logic [31:0] req_direction_one_y,
   input  logic [31:0] req_direction_one_z,
   input  logic [31:0] req_origin_two_x,
   input  logic [31:0] req_origin_two_y,
   input  logic [31:0] req_origin_two_z,
   input  logic [31:0] req_direction_two_x,
   input  logic [31:0] req_direction_two_y,
   input  logic [31:0] req_direction_two_z,
   output logic        rsp_strobe,
   output logic [31:0] rsp_param_one,
   output logic [31:0] rsp_param_two,
   output logic [31:0] rsp_separation,
   output logic        rsp_lines_parallel,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cpr_pkg::queue_stat_type q_stat;
   cpr_pkg::item_type       front_item, back_item;
   cpr_pkg::geom_type       geom;
   cpr_pkg::result_type     result;
   logic                    push;
   logic [31:0]             limit;

   cpr_front u_front (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .full    (q_stat.full),
      .o1      ({req_origin_one_z, req_origin_one_y, req_origin_one_x}),
      .d1      ({req_direction_one_z, req_direction_one_y, req_direction_one_x}),
      .o2      ({req_origin_two_z, req_origin_two_y, req_origin_two_x}),
      .d2      ({req_direction_two_z, req_direction_two_y, req_direction_two_x}),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .limit   (limit),
      .push    (push),
      .item    (front_item)
   );

   cpr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .stat      (q_stat),
      .pop_item  (back_item)
   );

   cpr_solve u_solve (
      .clock    (clock),
      .reset    (reset),
      .in_valid (q_stat.valid),
      .in_item  (back_item),
      .limit    (limit),
      .geom     (geom)
   );

   cpr_dist u_dist (
      .clock  (clock),
      .reset  (reset),
      .geom   (geom),
      .result (result)
   );

   assign busy               = q_stat.full;
   assign pready             = 1'b1;
   assign rsp_strobe         = result.valid;
   assign rsp_param_one      = result.param_one;
   assign rsp_param_two      = result.param_two;
   assign rsp_separation     = result.separation;
   assign rsp_lines_parallel = result.parallel;

endmodule

// ===== rtl/cpr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_front
// Item intake, origin difference, and the limit register on the APB port.
// ----------------------------------------------------------------------------
module cpr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  full,
   input  logic [2:0][31:0]      o1,
   input  logic [2:0][31:0]      d1,
   input  logic [2:0][31:0]      o2,
   input  logic [2:0][31:0]      d2,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic [31:0]           limit,
   output logic                  push,
   output cpr_pkg::item_type     item
);

   logic              valid_ff, valid_in;
   cpr_pkg::item_type item_ff, item_in;
   logic [31:0]       limit_ff, limit_in;

   always_comb begin
      valid_in = start && !full;
      item_in.d1 = d1;
      item_in.d2 = d2;
      for (int k = 0; k < 3; k++) begin
         item_in.w[k] = 33'($signed(o1[k])) - 33'($signed(o2[k]));
      end
      limit_in = limit_ff;
      if (psel && penable && pwrite && paddr[2] == cpr_pkg::IDX_LIMIT) begin
         limit_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         limit_ff <= cpr_pkg::LIMIT_RESET;
      end else begin
         valid_ff <= valid_in;
         limit_ff <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign prdata = (paddr[2] == cpr_pkg::IDX_LIMIT) ? limit_ff : 32'd0;
   assign limit  = limit_ff;
   assign push   = valid_ff;
   assign item   = item_ff;

endmodule

// ===== rtl/cpr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_queue
// Two-entry item queue between intake and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module cpr_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  cpr_pkg::item_type        push_item,
   output cpr_pkg::queue_stat_type  stat,
   output cpr_pkg::item_type        pop_item
);

   cpr_pkg::item_type mem [2];
   cpr_pkg::item_type out_item_ff;
   logic       out_valid_ff;
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   always_comb begin
      pop    = cnt_ff != 2'd0;
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff        <= 1'b0;
         rd_ff        <= 1'b0;
         cnt_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_ff        <= wr_in;
         rd_ff        <= rd_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_item;
      end
      if (pop) begin
         out_item_ff <= mem[rd_ff];
      end
   end

   assign stat.valid = out_valid_ff;
   assign stat.full  = cnt_ff == 2'd2;
   assign pop_item   = out_item_ff;

endmodule

// ===== rtl/cpr_solve.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_solve
// Dot products, determinant, parallel test and the two parameter dividers.
// ----------------------------------------------------------------------------
module cpr_solve (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  cpr_pkg::item_type  in_item,
   input  logic [31:0]        limit,
   output cpr_pkg::geom_type  geom
);

   localparam int unsigned NQ = cpr_pkg::DIV_STAGES;

   // stage 1
   logic                     v1_ff;
   cpr_pkg::item_type        it1_ff;
   logic signed [63:0]       uu_ff [3], uv_ff [3], vv_ff [3];
   logic signed [64:0]       uw_ff [3], vw_ff [3];
   // stage 2
   logic                     v2_ff;
   cpr_pkg::item_type        it2_ff;
   logic signed [67:0]       a2_ff, b2_ff, c2_ff, d2_ff, e2_ff;
   // partial products
   logic                     vm_ff;
   cpr_pkg::item_type        itm_ff;
   logic signed [67:0]       bm_ff, cm_ff, dm_ff, em_ff;
   logic signed [67:0]       hh_ff [6];
   logic signed [68:0]       hl_ff [6], lh_ff [6];
   logic signed [69:0]       ll_ff [6];
   logic signed [67:0]       mx [6], my [6];
   logic signed [33:0]       mxh [6], myh [6];
   logic signed [34:0]       mxl [6], myl [6];
   logic signed [135:0]      prod [6];
   // stage 3
   logic                     v3_ff;
   cpr_pkg::item_type        it3_ff;
   logic signed [135:0]      ac_ff, bb_ff, be_ff, cd_ff, ae_ff, bd_ff;
   logic signed [67:0]       b3_ff, c3_ff, d3_ff, e3_ff;
   // stage 4
   logic                     v4_ff, par4_ff;
   cpr_pkg::item_type        it4_ff;
   logic signed [151:0]      num4_ff [2];
   logic signed [135:0]      den4_ff [2];
   // stage 5
   logic                     v5_ff, par5_ff;
   cpr_pkg::item_type        it5_ff;
   logic                     neg5_ff [2];
   logic [151:0]             an5_ff [2];
   logic [135:0]             ad5_ff [2];
   // divider stages
   logic                     vq_ff [NQ+1];
   logic                     parq_ff [NQ+1];
   cpr_pkg::item_type        itq_ff [NQ+1];
   logic                     negq_ff [NQ+1][2], zq_ff [NQ+1][2], bigq_ff [NQ+1][2];
   logic [151:0]             remq_ff [NQ+1][2];
   logic [135:0]             adq_ff [NQ+1][2];
   logic [31:0]              qq_ff [NQ+1][2];
   logic [151:0]             rem_in [NQ][2];
   logic [31:0]              q_in [NQ][2];
   logic [167:0]             trial [NQ][2];
   // output
   cpr_pkg::geom_type        geom_ff, geom_in;

   logic signed [135:0]      det, n1, n2, lim;
   logic                     par, bgtc;
   logic signed [67:0]       psel_num, psel_den;
   logic [31:0]              res [2];

   always_comb begin
      mx[0] = a2_ff;
      my[0] = c2_ff;
      mx[1] = b2_ff;
      my[1] = b2_ff;
      mx[2] = b2_ff;
      my[2] = e2_ff;
      mx[3] = c2_ff;
      my[3] = d2_ff;
      mx[4] = a2_ff;
      my[4] = e2_ff;
      mx[5] = b2_ff;
      my[5] = d2_ff;
      for (int p = 0; p < 6; p++) begin
         mxh[p]  = mx[p][67:34];
         myh[p]  = my[p][67:34];
         mxl[p]  = {1'b0, mx[p][33:0]};
         myl[p]  = {1'b0, my[p][33:0]};
         prod[p] = (136'(hh_ff[p]) << 68) + (136'(hl_ff[p]) << 34)
                 + (136'(lh_ff[p]) << 34) + 136'(ll_ff[p]);
      end
   end

   always_comb begin
      det  = ac_ff - bb_ff;
      n1   = be_ff - cd_ff;
      n2   = ae_ff - bd_ff;
      lim  = $signed({72'd0, limit, 32'd0});
      par  = det < lim;
      bgtc = b3_ff > c3_ff;
      psel_num = bgtc ? d3_ff : e3_ff;
      psel_den = bgtc ? b3_ff : c3_ff;
   end

   always_comb begin
      for (int s = 0; s < NQ; s++) begin
         for (int l = 0; l < 2; l++) begin
            trial[s][l] = {32'd0, adq_ff[s][l]} << (NQ - 1 - s);
            if ({16'd0, remq_ff[s][l]} >= trial[s][l]) begin
               rem_in[s][l] = remq_ff[s][l] - trial[s][l][151:0];
               q_in[s][l]   = qq_ff[s][l] | (32'd1 << (NQ - 1 - s));
            end else begin
               rem_in[s][l] = remq_ff[s][l];
               q_in[s][l]   = qq_ff[s][l];
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (zq_ff[NQ][l]) begin
            res[l] = 32'd0;
         end else if (negq_ff[NQ][l]) begin
            if (bigq_ff[NQ][l] || qq_ff[NQ][l] > 32'h8000_0000) begin
               res[l] = 32'h8000_0000;
            end else begin
               res[l] = -qq_ff[NQ][l];
            end
         end else if (bigq_ff[NQ][l] || qq_ff[NQ][l][31]) begin
            res[l] = 32'h7FFF_FFFF;
         end else begin
            res[l] = qq_ff[NQ][l];
         end
      end
      geom_in.valid    = vq_ff[NQ];
      geom_in.parallel = parq_ff[NQ];
      geom_in.sc       = res[0];
      geom_in.tc       = res[1];
      geom_in.item     = itq_ff[NQ];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         vm_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         for (int s = 0; s <= NQ; s++) begin
            vq_ff[s] <= 1'b0;
         end
         geom_ff.valid <= 1'b0;
      end else begin
         v1_ff    <= in_valid;
         v2_ff    <= v1_ff;
         vm_ff    <= v2_ff;
         v3_ff    <= vm_ff;
         v4_ff    <= v3_ff;
         v5_ff    <= v4_ff;
         vq_ff[0] <= v5_ff;
         for (int s = 0; s < NQ; s++) begin
            vq_ff[s+1] <= vq_ff[s];
         end
         geom_ff.valid <= geom_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      it1_ff <= in_item;
      for (int k = 0; k < 3; k++) begin
         uu_ff[k] <= $signed(in_item.d1[k]) * $signed(in_item.d1[k]);
         uv_ff[k] <= $signed(in_item.d1[k]) * $signed(in_item.d2[k]);
         vv_ff[k] <= $signed(in_item.d2[k]) * $signed(in_item.d2[k]);
         uw_ff[k] <= 65'($signed(in_item.d1[k])) * 65'($signed(in_item.w[k]));
         vw_ff[k] <= 65'($signed(in_item.d2[k])) * 65'($signed(in_item.w[k]));
      end

      it2_ff <= it1_ff;
      a2_ff  <= 68'(uu_ff[0]) + 68'(uu_ff[1]) + 68'(uu_ff[2]);
      b2_ff  <= 68'(uv_ff[0]) + 68'(uv_ff[1]) + 68'(uv_ff[2]);
      c2_ff  <= 68'(vv_ff[0]) + 68'(vv_ff[1]) + 68'(vv_ff[2]);
      d2_ff  <= 68'(uw_ff[0]) + 68'(uw_ff[1]) + 68'(uw_ff[2]);
      e2_ff  <= 68'(vw_ff[0]) + 68'(vw_ff[1]) + 68'(vw_ff[2]);

      itm_ff <= it2_ff;
      bm_ff  <= b2_ff;
      cm_ff  <= c2_ff;
      dm_ff  <= d2_ff;
      em_ff  <= e2_ff;
      for (int p = 0; p < 6; p++) begin
         hh_ff[p] <= mxh[p] * myh[p];
         hl_ff[p] <= mxh[p] * myl[p];
         lh_ff[p] <= mxl[p] * myh[p];
         ll_ff[p] <= mxl[p] * myl[p];
      end

      it3_ff <= itm_ff;
      ac_ff  <= prod[0];
      bb_ff  <= prod[1];
      be_ff  <= prod[2];
      cd_ff  <= prod[3];
      ae_ff  <= prod[4];
      bd_ff  <= prod[5];
      b3_ff  <= bm_ff;
      c3_ff  <= cm_ff;
      d3_ff  <= dm_ff;
      e3_ff  <= em_ff;

      it4_ff     <= it3_ff;
      par4_ff    <= par;
      num4_ff[0] <= $signed({n1, 16'd0});
      den4_ff[0] <= det;
      if (par) begin
         num4_ff[1] <= $signed({136'(psel_num), 16'd0});
         den4_ff[1] <= 136'(psel_den);
      end else begin
         num4_ff[1] <= $signed({n2, 16'd0});
         den4_ff[1] <= det;
      end

      it5_ff  <= it4_ff;
      par5_ff <= par4_ff;
      for (int l = 0; l < 2; l++) begin
         neg5_ff[l] <= num4_ff[l][151] ^ den4_ff[l][135];
         an5_ff[l]  <= num4_ff[l][151] ? 152'(-num4_ff[l]) : 152'(num4_ff[l]);
         ad5_ff[l]  <= den4_ff[l][135] ? 136'(-den4_ff[l]) : 136'(den4_ff[l]);
      end

      itq_ff[0]  <= it5_ff;
      parq_ff[0] <= par5_ff;
      for (int l = 0; l < 2; l++) begin
         negq_ff[0][l] <= neg5_ff[l];
         bigq_ff[0][l] <= {16'd0, an5_ff[l]} >= {ad5_ff[l], 32'd0};
         remq_ff[0][l] <= an5_ff[l];
         adq_ff[0][l]  <= ad5_ff[l];
         qq_ff[0][l]   <= 32'd0;
      end
      zq_ff[0][0] <= par5_ff || ad5_ff[0] == 136'd0;
      zq_ff[0][1] <= ad5_ff[1] == 136'd0;

      for (int s = 0; s < NQ; s++) begin
         itq_ff[s+1]  <= itq_ff[s];
         parq_ff[s+1] <= parq_ff[s];
         for (int l = 0; l < 2; l++) begin
            negq_ff[s+1][l] <= negq_ff[s][l];
            zq_ff[s+1][l]   <= zq_ff[s][l];
            bigq_ff[s+1][l] <= bigq_ff[s][l];
            adq_ff[s+1][l]  <= adq_ff[s][l];
            remq_ff[s+1][l] <= rem_in[s][l];
            qq_ff[s+1][l]   <= q_in[s][l];
         end
      end

      geom_ff.parallel <= geom_in.parallel;
      geom_ff.sc       <= geom_in.sc;
      geom_ff.tc       <= geom_in.tc;
      geom_ff.item     <= geom_in.item;
   end

   assign geom = geom_ff;

endmodule

// ===== rtl/cpr_dist.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_dist
// Closest-point difference, squared length and pipelined integer root.
// ----------------------------------------------------------------------------
module cpr_dist (
   input  logic                 clock,
   input  logic                 reset,
   input  cpr_pkg::geom_type    geom,
   output cpr_pkg::result_type  result
);

   localparam int unsigned NR = cpr_pkg::ROOT_STAGES;

   logic                v1_ff, v2_ff, vm_ff, v3_ff, v4_ff;
   logic                p1_ff, p2_ff, pm_ff, p3_ff, p4_ff;
   logic [31:0]         sc1_ff, tc1_ff, sc2_ff, tc2_ff, sc3_ff, tc3_ff, sc4_ff, tc4_ff;
   logic [31:0]         scm_ff, tcm_ff;
   logic signed [63:0]  m1_ff [3], m2_ff [3];
   logic signed [48:0]  ws_ff [3];
   logic signed [67:0]  dp_ff [3];
   logic signed [33:0]  dh [3];
   logic signed [34:0]  dl [3];
   logic signed [67:0]  sqhh_ff [3];
   logic signed [68:0]  sqhl_ff [3];
   logic signed [69:0]  sqll_ff [3];
   logic [135:0]        sq_ff [3];
   logic [135:0]        sum4_ff;

   logic                vr_ff [NR+1], pr_ff [NR+1], satr_ff [NR+1];
   logic [31:0]         scr_ff [NR+1], tcr_ff [NR+1];
   logic [63:0]         nr_ff [NR+1];
   logic [35:0]         remr_ff [NR+1];
   logic [31:0]         rootr_ff [NR+1];
   logic [35:0]         rem_pre [NR], tst [NR], rem_in [NR];
   logic [31:0]         root_in [NR];

   cpr_pkg::result_type res_ff, res_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dh[k] = dp_ff[k][67:34];
         dl[k] = {1'b0, dp_ff[k][33:0]};
      end
      for (int s = 0; s < NR; s++) begin
         rem_pre[s] = {remr_ff[s][33:0], nr_ff[s][63:62]};
         tst[s]     = {2'b00, rootr_ff[s], 2'b01};
         if (rem_pre[s] >= tst[s]) begin
            rem_in[s]  = rem_pre[s] - tst[s];
            root_in[s] = {rootr_ff[s][30:0], 1'b1};
         end else begin
            rem_in[s]  = rem_pre[s];
            root_in[s] = {rootr_ff[s][30:0], 1'b0};
         end
      end
      res_in.valid      = vr_ff[NR];
      res_in.parallel   = pr_ff[NR];
      res_in.param_one  = scr_ff[NR];
      res_in.param_two  = tcr_ff[NR];
      res_in.separation = satr_ff[NR] ? 32'hFFFF_FFFF : rootr_ff[NR];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         vm_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         for (int s = 0; s <= NR; s++) begin
            vr_ff[s] <= 1'b0;
         end
         res_ff.valid <= 1'b0;
      end else begin
         v1_ff    <= geom.valid;
         v2_ff    <= v1_ff;
         vm_ff    <= v2_ff;
         v3_ff    <= vm_ff;
         v4_ff    <= v3_ff;
         vr_ff[0] <= v4_ff;
         for (int s = 0; s < NR; s++) begin
            vr_ff[s+1] <= vr_ff[s];
         end
         res_ff.valid <= res_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff  <= geom.parallel;
      sc1_ff <= geom.sc;
      tc1_ff <= geom.tc;
      for (int k = 0; k < 3; k++) begin
         m1_ff[k] <= $signed(geom.sc) * $signed(geom.item.d1[k]);
         m2_ff[k] <= $signed(geom.tc) * $signed(geom.item.d2[k]);
         ws_ff[k] <= $signed({geom.item.w[k], 16'd0});
      end

      p2_ff  <= p1_ff;
      sc2_ff <= sc1_ff;
      tc2_ff <= tc1_ff;
      for (int k = 0; k < 3; k++) begin
         dp_ff[k] <= 68'(ws_ff[k]) + 68'(m1_ff[k]) - 68'(m2_ff[k]);
      end

      pm_ff  <= p2_ff;
      scm_ff <= sc2_ff;
      tcm_ff <= tc2_ff;
      for (int k = 0; k < 3; k++) begin
         sqhh_ff[k] <= dh[k] * dh[k];
         sqhl_ff[k] <= dh[k] * dl[k];
         sqll_ff[k] <= dl[k] * dl[k];
      end

      p3_ff  <= pm_ff;
      sc3_ff <= scm_ff;
      tc3_ff <= tcm_ff;
      for (int k = 0; k < 3; k++) begin
         sq_ff[k] <= (136'(sqhh_ff[k]) << 68) + (136'(sqhl_ff[k]) << 35)
                   + 136'(sqll_ff[k]);
      end

      p4_ff   <= p3_ff;
      sc4_ff  <= sc3_ff;
      tc4_ff  <= tc3_ff;
      sum4_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];

      pr_ff[0]    <= p4_ff;
      scr_ff[0]   <= sc4_ff;
      tcr_ff[0]   <= tc4_ff;
      satr_ff[0]  <= |sum4_ff[135:96];
      nr_ff[0]    <= sum4_ff[95:32];
      remr_ff[0]  <= 36'd0;
      rootr_ff[0] <= 32'd0;
      for (int s = 0; s < NR; s++) begin
         pr_ff[s+1]    <= pr_ff[s];
         scr_ff[s+1]   <= scr_ff[s];
         tcr_ff[s+1]   <= tcr_ff[s];
         satr_ff[s+1]  <= satr_ff[s];
         nr_ff[s+1]    <= {nr_ff[s][61:0], 2'b00};
         remr_ff[s+1]  <= rem_in[s];
         rootr_ff[s+1] <= root_in[s];
      end

      res_ff.parallel   <= res_in.parallel;
      res_ff.param_one  <= res_in.param_one;
      res_ff.param_two  <= res_in.param_two;
      res_ff.separation <= res_in.separation;
   end

   assign result = res_ff;

endmodule
